### rtl/core/pfa_pkg.sv
// Package with payload types, configuration codes and controller states of the allocator.
package pfa_pkg;

	// Widths of the transaction fields.
	localparam int unsigned INDEX_W   = 4;
	localparam int unsigned VALUE_W   = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 5;
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned COUNT_W   = 5;

	// Item kinds.
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	// Placement policies; the unused code behaves as best fit.
	localparam logic [MODE_W-1:0] MODE_BEST  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd1;

	// Reset values of the configuration registers.
	localparam logic [MODE_W-1:0]  FIT_MODE_RESET    = MODE_BEST;
	localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 5'd16;

	typedef struct packed {
		logic               op;
		logic [INDEX_W-1:0] load_index;
		logic [VALUE_W-1:0] size_value;
	} in_t;

	typedef struct packed {
		logic               granted;
		logic [INDEX_W-1:0] block_index;
		logic [VALUE_W-1:0] space_before;
		logic [VALUE_W-1:0] space_after;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_WAIT = 3'b100
	} state_t;

endpackage

### rtl/core/pfa_cell.sv
// One partition cell: holds the free space of one partition and passes the search token on.
module pfa_cell import pfa_pkg::*; #(
	parameter int unsigned CELL_INDEX = 0,
	parameter int unsigned IDX_W      = 4,
	parameter int unsigned SIZE_W     = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [MODE_W-1:0]  fit_mode,
	input  logic [COUNT_W-1:0] block_count,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_idx,
	input  logic [SIZE_W-1:0]  wr_data,
	input  logic               tok_in_valid,
	input  logic               tok_in_found,
	input  logic [IDX_W-1:0]   tok_in_idx,
	input  logic [SIZE_W-1:0]  tok_in_space,
	input  logic [SIZE_W-1:0]  tok_in_size,
	output logic               tok_out_valid,
	output logic               tok_out_found,
	output logic [IDX_W-1:0]   tok_out_idx,
	output logic [SIZE_W-1:0]  tok_out_space,
	output logic [SIZE_W-1:0]  tok_out_size
);

	localparam logic [8:0]       POS    = 9'(CELL_INDEX);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

	logic [SIZE_W-1:0] entry_q;
	logic              valid_q;
	logic              found_q;
	logic [IDX_W-1:0]  idx_q;
	logic [SIZE_W-1:0] space_q;
	logic [SIZE_W-1:0] size_q;
	logic              active;
	logic              fits;
	logic              better;
	logic              take;

	// Free space store of this partition.
	always_ff @(posedge clk) begin
		if (wr_en && (wr_idx == MY_IDX)) begin
			entry_q <= wr_data;
		end
	end

	// Decide whether this partition replaces the candidate carried by the token.
	always_comb begin
		active = (9'(block_count) > POS);
		fits   = (entry_q >= tok_in_size);
		if (fit_mode == MODE_WORST) begin
			better = (entry_q > tok_in_space);
		end else begin
			better = (entry_q < tok_in_space);
		end
		take = tok_in_valid && active && fits &&
			(!tok_in_found || ((fit_mode != MODE_FIRST) && better));
	end

	// Token valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_in_valid;
		end
	end

	// Token payload handed to the next cell.
	always_ff @(posedge clk) begin
		size_q <= tok_in_size;
		if (take) begin
			found_q <= 1'b1;
			idx_q   <= MY_IDX;
			space_q <= entry_q;
		end else begin
			found_q <= tok_in_found;
			idx_q   <= tok_in_idx;
			space_q <= tok_in_space;
		end
	end

	assign tok_out_valid = valid_q;
	assign tok_out_found = found_q;
	assign tok_out_idx   = idx_q;
	assign tok_out_space = space_q;
	assign tok_out_size  = size_q;

endmodule

### rtl/core/partition_fit_allocator_core.sv
// Fixed-partition allocator: free space table in a chain of cells with first, best and worst fit.
//
// Usage:
//   The input channel (in_valid, in_stall, in_data) takes load and request transactions.
//   A load writes one partition's size in the cycle it is accepted and returns nothing.
//   A request sends a search token down the row of NUM_BLOCKS cells, one cell per cycle;
//   each cell compares its stored free space against the token's current candidate.
//   When the token leaves the last cell, the chosen entry is reduced by the request size
//   and one result transaction is loaded into the output register.
//   A request's result is registered once its token has crossed the last cell, and a new
//   transaction is taken in the cycle after the result is registered, so requests do not
//   overlap; loads are taken one per cycle while no request is in flight.
//   The output register (out_valid, out_stall, out_data) holds a result while stalled;
//   a following load is still accepted, and a following request finishes its scan and
//   then waits, keeping its result and write-back until the output register is free.
//   Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready and must
//   be written only while no request is in flight.
//   Reset clears the control state and sets best fit with sixteen partitions; the free
//   space table is undefined until each entry is loaded.
module partition_fit_allocator_core import pfa_pkg::*; #(
	parameter int unsigned NUM_BLOCKS = 16,
	parameter int unsigned SIZE_BITS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_t                 out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int unsigned IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int unsigned SIZE_W = SIZE_BITS;

	state_t             state_q;
	logic [MODE_W-1:0]  fit_mode_q;
	logic [COUNT_W-1:0] block_count_q;

	// Token signals along the chain; element zero is the injected token.
	logic [NUM_BLOCKS:0] tv;
	logic [NUM_BLOCKS:0] tf;
	logic [IDX_W-1:0]    ti [NUM_BLOCKS+1];
	logic [SIZE_W-1:0]   tsp [NUM_BLOCKS+1];
	logic [SIZE_W-1:0]   tsz [NUM_BLOCKS+1];

	logic              in_accept;
	logic              req_accept;
	logic              load_accept;
	logic [8:0]        load_idx_ext;
	logic              load_in_range;
	logic [SIZE_W-1:0] in_size;

	logic              res_found_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic [SIZE_W-1:0] res_space_q;
	logic [SIZE_W-1:0] res_size_q;

	logic              src_found;
	logic [IDX_W-1:0]  src_idx;
	logic [SIZE_W-1:0] src_space;
	logic [SIZE_W-1:0] src_size;
	logic [SIZE_W-1:0] src_after;
	logic              out_free;
	logic              finish;
	logic              emit;

	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;
	logic [SIZE_W-1:0] wr_data;

	logic              out_valid_q;
	out_t              out_data_q;
	out_t              result;

	// Input handshake and decoding.
	always_comb begin
		in_stall      = (state_q != ST_IDLE);
		in_accept     = in_valid && !in_stall;
		req_accept    = in_accept && (in_data.op == OP_REQUEST);
		load_accept   = in_accept && (in_data.op == OP_LOAD);
		load_idx_ext  = 9'(in_data.load_index);
		load_in_range = (load_idx_ext < 9'(NUM_BLOCKS));
		in_size       = SIZE_W'(32'(in_data.size_value));
	end

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q    <= FIT_MODE_RESET;
			block_count_q <= BLOCK_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FIT_MODE:    fit_mode_q    <= cfg_data[MODE_W-1:0];
				CFG_BLOCK_COUNT: block_count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Fresh token entering the first cell.
	always_comb begin
		tv[0]  = req_accept;
		tf[0]  = 1'b0;
		ti[0]  = '0;
		tsp[0] = '0;
		tsz[0] = in_size;
	end

	// Row of partition cells.
	for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
		pfa_cell #(
			.CELL_INDEX(g),
			.IDX_W     (IDX_W),
			.SIZE_W    (SIZE_W)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.fit_mode     (fit_mode_q),
			.block_count  (block_count_q),
			.wr_en        (wr_en),
			.wr_idx       (wr_idx),
			.wr_data      (wr_data),
			.tok_in_valid (tv[g]),
			.tok_in_found (tf[g]),
			.tok_in_idx   (ti[g]),
			.tok_in_space (tsp[g]),
			.tok_in_size  (tsz[g]),
			.tok_out_valid(tv[g+1]),
			.tok_out_found(tf[g+1]),
			.tok_out_idx  (ti[g+1]),
			.tok_out_space(tsp[g+1]),
			.tok_out_size (tsz[g+1])
		);
	end

	// Finished search: from the chain's tail, or from the holding register while waiting.
	always_comb begin
		out_free = !out_valid_q || !out_stall;
		finish   = (state_q == ST_SCAN) && tv[NUM_BLOCKS];
		emit     = out_free && (finish || (state_q == ST_WAIT));
		if (state_q == ST_WAIT) begin
			src_found = res_found_q;
			src_idx   = res_idx_q;
			src_space = res_space_q;
			src_size  = res_size_q;
		end else begin
			src_found = tf[NUM_BLOCKS];
			src_idx   = ti[NUM_BLOCKS];
			src_space = tsp[NUM_BLOCKS];
			src_size  = tsz[NUM_BLOCKS];
		end
		src_after = src_space - src_size;
	end

	// Result transaction; a refused request reports zeros.
	always_comb begin
		result = '0;
		if (src_found) begin
			result.granted      = 1'b1;
			result.block_index  = INDEX_W'(src_idx);
			result.space_before = VALUE_W'(32'(src_space));
			result.space_after  = VALUE_W'(32'(src_after));
		end
	end

	// Shared write port: write-back of a grant, otherwise a load.
	always_comb begin
		if (emit) begin
			wr_en   = src_found;
			wr_idx  = src_idx;
			wr_data = src_after;
		end else begin
			wr_en   = load_accept && load_in_range;
			wr_idx  = load_idx_ext[IDX_W-1:0];
			wr_data = in_size;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (finish) begin
						state_q <= out_free ? ST_IDLE : ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Holds a finished search while the output register is occupied.
	always_ff @(posedge clk) begin
		if (finish && !out_free) begin
			res_found_q <= tf[NUM_BLOCKS];
			res_idx_q   <= ti[NUM_BLOCKS];
			res_space_q <= tsp[NUM_BLOCKS];
			res_size_q  <= tsz[NUM_BLOCKS];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// At most one search token is in the chain.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tv[NUM_BLOCKS:1]))
		else $error("more than one search token in the cell chain");

	// A token only leaves the chain while a scan is running.
	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tv[NUM_BLOCKS] |-> (state_q == ST_SCAN))
		else $error("search token reached the tail outside a scan");

	// A request arriving at the head reaches the tail, moving on by one cell per cycle.
	a_scan_length: assert property (@(posedge clk) disable iff (!arst_n)
		req_accept |-> ##(NUM_BLOCKS) tv[NUM_BLOCKS])
		else $error("search token did not cross the chain in time");

	// A refused request carries zero fields.
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_data_q.granted) |->
		((out_data_q.block_index == '0) && (out_data_q.space_before == '0) &&
		 (out_data_q.space_after == '0)))
		else $error("refused result has nonzero fields");

	// A grant never leaves more space than it started with.
	a_grant_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.granted) |->
		(out_data_q.space_after <= out_data_q.space_before))
		else $error("granted result grew the free space");

endmodule

### tb/partition_fit_allocator_core_tb.sv
// Self-checking testbench for the fixed-partition fit allocator core.
`timescale 1ns / 100ps

module partition_fit_allocator_core_tb;
	import pfa_pkg::*;

	localparam int unsigned NUM_BLOCKS = 16;
	localparam int unsigned SIZE_BITS  = 16;

	// Spare fit mode code; the block treats it as best fit.
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	// Cycles let pass after the last result before the block counts as idle.
	localparam int SETTLE_CYCLES = NUM_BLOCKS + 8;
	// Length of the long output hold-off.
	localparam int HOLD_CYCLES = 400;
	// Cycles without any transaction before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 135;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_t                  in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_t                 out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	// Shadow copy of the partition table and the configuration registers.
	logic [VALUE_W-1:0] shadow_space [NUM_BLOCKS];
	logic [MODE_W-1:0]  shadow_mode = FIT_MODE_RESET;
	logic [COUNT_W-1:0] shadow_count = BLOCK_COUNT_RESET;

	// Allocation results still owed by the block, oldest first.
	out_t awaited_allocs [$];
	out_t oldest_alloc;

	logic [VALUE_W-1:0] seed_sizes [NUM_BLOCKS];

	int fail_count = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;

	partition_fit_allocator_core #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.SIZE_BITS (SIZE_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Apply one accepted transaction to the shadow table and queue the allocation it yields.
	function automatic void predict_item(in_t it);
		out_t res;
		int   lim;
		int   pick;
		bit   found;
		bit   better;
		res = '0;
		pick = 0;
		found = 1'b0;
		if (it.op == OP_LOAD) begin
			shadow_space[it.load_index] = it.size_value;
			return;
		end
		lim = (shadow_count > NUM_BLOCKS) ? NUM_BLOCKS : shadow_count;
		// First fit stops at the first candidate; the others scan the whole range.
		for (int j = 0; j < lim && !(found && shadow_mode == MODE_FIRST); j++) begin
			if (shadow_space[j] >= it.size_value) begin
				if (!found) begin
					pick = j;
					found = 1'b1;
				end else begin
					if (shadow_mode == MODE_WORST)
						better = shadow_space[j] > shadow_space[pick];
					else
						better = shadow_space[j] < shadow_space[pick];
					if (better)
						pick = j;
				end
			end
		end
		if (found) begin
			res.granted = 1'b1;
			res.block_index = pick[INDEX_W-1:0];
			res.space_before = shadow_space[pick];
			shadow_space[pick] = shadow_space[pick] - it.size_value;
			res.space_after = shadow_space[pick];
		end
		awaited_allocs.push_back(res);
	endfunction

	function automatic in_t make_item(logic op, int idx, logic [VALUE_W-1:0] size);
		in_t it;
		it.op = op;
		it.load_index = idx[INDEX_W-1:0];
		it.size_value = size;
		return it;
	endfunction

	// Random transaction: sizes mix exact fits, near misses, extremes, small and random values.
	function automatic in_t random_item(bit force_request);
		in_t it;
		it.op = (force_request || $urandom_range(99) < 62) ? OP_REQUEST : OP_LOAD;
		it.load_index = INDEX_W'($urandom_range(NUM_BLOCKS - 1));
		case ($urandom_range(9))
			0: it.size_value = '0;
			1: it.size_value = '1;
			2, 3: it.size_value = VALUE_W'($urandom_range(255));
			4: it.size_value = shadow_space[INDEX_W'($urandom_range(NUM_BLOCKS - 1))];
			5: it.size_value = shadow_space[INDEX_W'($urandom_range(NUM_BLOCKS - 1))] + 1'b1;
			default: it.size_value = VALUE_W'($urandom);
		endcase
		return it;
	endfunction

	// Offer one transaction, idling at random first, and predict it once accepted.
	task automatic send_item(in_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_item(it);
	endtask

	// Stop offering, wait for every owed result, then let a trailing scan finish.
	task automatic wait_until_quiet();
		in_valid <= 1'b0;
		while (awaited_allocs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		wait_until_quiet();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_FIT_MODE)
			shadow_mode = val[MODE_W-1:0];
		else if (idx == CFG_BLOCK_COUNT)
			shadow_count = val[COUNT_W-1:0];
	endtask

	task automatic configure(logic [MODE_W-1:0] mode, int count);
		write_register(CFG_FIT_MODE, CFG_DAT_W'(mode));
		write_register(CFG_BLOCK_COUNT, CFG_DAT_W'(count));
	endtask

	task automatic set_idling(int send_pct, int stall_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
	endtask

	// Fill every partition, with ties and extremes, then allocate under the reset settings.
	task automatic test_reset_best_fit();
		seed_sizes = '{16'd500, 16'd300, 16'd300, 16'hFFFF, 16'd0, 16'd1000, 16'd300,
			16'hFFFF, 16'd20, 16'd4000, 16'd0, 16'd7, 16'h8000, 16'd1, 16'd999, 16'hFFFE};
		set_idling(0, 0);
		for (int i = 0; i < NUM_BLOCKS; i++)
			send_item(make_item(OP_LOAD, i, seed_sizes[i]));
		send_item(make_item(OP_REQUEST, 5, 16'd300));
		// A zero-size request fits even an empty partition.
		send_item(make_item(OP_REQUEST, 0, 16'd0));
		send_item(make_item(OP_REQUEST, 15, 16'hFFFF));
		send_item(make_item(OP_REQUEST, 9, 16'hFFFF));
		// Both full-size partitions are used up, so this one is refused.
		send_item(make_item(OP_REQUEST, 3, 16'hFFFF));
	endtask

	task automatic test_fit_modes();
		configure(MODE_FIRST, NUM_BLOCKS);
		send_item(make_item(OP_REQUEST, 0, 16'd250));
		configure(MODE_WORST, NUM_BLOCKS);
		send_item(make_item(OP_REQUEST, 0, 16'd10));
		// The spare mode code must behave as best fit.
		configure(MODE_UNUSED, NUM_BLOCKS);
		send_item(make_item(OP_REQUEST, 0, 16'd5));
	endtask

	task automatic test_block_count_limits();
		// With no partition in range every request is refused.
		configure(MODE_BEST, 0);
		send_item(make_item(OP_REQUEST, 0, 16'd0));
		// Counts above the table size saturate to the full table.
		configure(MODE_BEST, 31);
		send_item(make_item(OP_REQUEST, 0, 16'd1));
		configure(MODE_WORST, 1);
		send_item(make_item(OP_REQUEST, 0, 16'd0));
	endtask

	// Random loads and requests over several settings and idling patterns.
	task automatic test_random_traffic();
		int count;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: count = NUM_BLOCKS;
				1: count = 1;
				2: count = NUM_BLOCKS + 1 + $urandom_range(14);
				default: count = $urandom_range(NUM_BLOCKS, 1);
			endcase
			configure(MODE_W'((p + p / 4) % 4), count);
			case (p % 4)
				0: set_idling(0, 0);
				1: set_idling(77, 0);
				2: set_idling(0, 77);
				default: set_idling(6, 6);
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_item(random_item(1'b0));
		end
	endtask

	// Hold the output long enough for the block to back up, let it drain, then send more traffic.
	task automatic test_output_hold();
		configure(MODE_BEST, NUM_BLOCKS);
		set_idling(0, 0);
		hold_req = 1'b1;
		for (int i = 0; i < 30; i++)
			send_item(random_item(1'b1));
		wait_until_quiet();
		for (int i = 0; i < 40; i++)
			send_item(random_item(1'b0));
	endtask

	// Result checker and output stall control.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_allocs.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: granted=%0d block=%0d before=%0d after=%0d",
						out_data.granted, out_data.block_index, out_data.space_before,
						out_data.space_after);
			end else begin
				oldest_alloc = awaited_allocs.pop_front();
				if (out_data.granted !== oldest_alloc.granted ||
						out_data.block_index !== oldest_alloc.block_index ||
						out_data.space_before !== oldest_alloc.space_before ||
						out_data.space_after !== oldest_alloc.space_after) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch at %0t: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
							$realtime, oldest_alloc.granted, oldest_alloc.block_index,
							oldest_alloc.space_before, oldest_alloc.space_after,
							out_data.granted, out_data.block_index,
							out_data.space_before, out_data.space_after);
				end
			end
		end
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Count cycles in which no transaction moves on any channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		for (int i = 0; i < NUM_BLOCKS; i++)
			shadow_space[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_best_fit();
		test_fit_modes();
		test_block_count_limits();
		test_random_traffic();
		test_output_hold();
		wait_until_quiet();
		if (fail_count == 0 && awaited_allocs.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### files.f
rtl/core/pfa_pkg.sv
rtl/core/pfa_cell.sv
rtl/core/partition_fit_allocator_core.sv
tb/partition_fit_allocator_core_tb.sv
